// File: hw/rtl/mcb_pkg.sv
// Shared types and constants for the multichannel colour blend pipeline.
`default_nettype none
package mcb_pkg;

    localparam int CHANNELS      = 4;
    localparam int TABLE_ENTRIES = 256;
    localparam int SAMPLE_BITS   = 16;
    localparam int FRAC_BITS     = 16;
    localparam int TIDX_BITS     = 8;
    localparam int TVAL_BITS     = 17;
    localparam int TCH_BITS      = 2;
    localparam int SETUP_BITS    = 58;
    localparam int CFG_IDX_BITS  = 3;
    localparam int COUNT_BITS    = 3;
    localparam int COLOR_BITS    = 8;
    localparam int COMPONENTS    = 3;
    localparam int DIV_STAGES    = FRAC_BITS;
    localparam int GAMMA_LAT     = 3;
    localparam int META_DEPTH    = DIV_STAGES + GAMMA_LAT;
    // Input register, divider, gamma unit, colour scaling, sum and output.
    localparam int PIPE_LAT      = 1 + DIV_STAGES + GAMMA_LAT + 2;
    localparam int SUM_BITS      = COLOR_BITS + $clog2(CHANNELS + 1);

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_FULL,
        KIND_FRAC
    } t_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_COUNT  = 3'd0,
        CFG_SETUP0 = 3'd1,
        CFG_SETUP1 = 3'd2,
        CFG_SETUP2 = 3'd3,
        CFG_SETUP3 = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                  gamma_en;
        logic                  visible;
        logic [COLOR_BITS-1:0] blue;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] red;
        logic [15:0]           hdr_max;
        logic [15:0]           hdr_min;
    } t_setup;

    // One gamma table write travelling to a channel's table.
    typedef struct packed {
        logic                 we;
        logic [TIDX_BITS-1:0] idx;
        logic [TVAL_BITS-1:0] value;
    } t_twr;

    typedef struct packed {
        logic                  valid;
        logic                  mode;
        t_kind [CHANNELS-1:0]  kind;
        logic [TCH_BITS-1:0]   tch;
        logic [TIDX_BITS-1:0]  tidx;
        logic [TVAL_BITS-1:0]  tval;
    } t_meta;

    localparam logic [COUNT_BITS-1:0] COUNT_RST = 3'd4;
    localparam logic [SETUP_BITS-1:0] SETUP_RST [0:3] = '{
        58'h100_00FF_0FFF_0000,
        58'h100_FF00_0FFF_0000,
        58'h1FF_0000_0FFF_0000,
        58'h0AA_AAAA_0FFF_0000
    };

endpackage
`default_nettype wire

// File: hw/rtl/mcb_divider.sv
// Pipelined restoring divider giving one quotient bit per stage.
`default_nettype none
module mcb_divider
    import mcb_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic [SAMPLE_BITS-1:0] i_dividend,
    input  wire logic [SAMPLE_BITS-1:0] i_divisor,
    output      logic [FRAC_BITS-1:0]   o_quot
);

    logic [SAMPLE_BITS-1:0] r_rem  [0:DIV_STAGES-2];
    logic [FRAC_BITS-1:0]   r_quot [0:DIV_STAGES-1];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        logic [SAMPLE_BITS-1:0] rem_in;
        logic [FRAC_BITS-1:0]   q_in;
        logic [SAMPLE_BITS:0]   sh;
        logic [SAMPLE_BITS:0]   diff;
        logic                   take;

        if (j == 0) begin : g_first
            assign rem_in = i_dividend;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign q_in   = r_quot[j-1];
        end

        // The remainder stays below the divisor, so a borrow is the top bit.
        assign sh   = {rem_in, 1'b0};
        assign diff = sh - {1'b0, i_divisor};
        assign take = ~diff[SAMPLE_BITS];

        always_ff @(posedge i_clk) begin
            r_quot[j] <= {q_in[FRAC_BITS-2:0], take};
        end

        if (j < DIV_STAGES - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[j] <= take ? diff[SAMPLE_BITS-1:0] : sh[SAMPLE_BITS-1:0];
            end
        end
    end

    assign o_quot = r_quot[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: hw/rtl/mcb_gamma.sv
// Per-channel gamma table with linear interpolation between neighbouring entries.
`default_nettype none
module mcb_gamma
    import mcb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic [FRAC_BITS-1:0] i_frac,
    input  wire logic                 i_gamma_en,
    input  wire t_twr                 i_wr,
    output      logic [FRAC_BITS:0]   o_frac
);

    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [TVAL_BITS-1:0] r_mem [0:TABLE_ENTRIES-1];

    logic [FRAC_BITS+TIDX_BITS-1:0] pos;
    logic [TIDX_BITS-1:0]           k0;
    logic [TIDX_BITS-1:0]           k1;

    logic [TVAL_BITS-1:0] r_t0;
    logic [TVAL_BITS-1:0] r_t1;
    logic [FRAC_BITS-1:0] r_r1;
    logic [FRAC_BITS-1:0] r_f1;
    logic                 r_g1;

    logic signed [TVAL_BITS:0]             n_diff;
    logic signed [TVAL_BITS+FRAC_BITS+1:0] r_prod;
    logic [TVAL_BITS-1:0]                  r_t0_2;
    logic [FRAC_BITS-1:0]                  r_f2;
    logic                                  r_g2;

    logic signed [TVAL_BITS+FRAC_BITS+1:0] num;
    logic [TVAL_BITS+1:0]                  gam;
    logic [FRAC_BITS:0]                    r_fout;

    // Position in the table is the fraction times (entries - 1).
    assign pos = {i_frac, TIDX_BITS'(0)} - {TIDX_BITS'(0), i_frac};
    assign k0  = pos[FRAC_BITS+TIDX_BITS-1:FRAC_BITS];
    assign k1  = k0 + TIDX_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.idx] <= i_wr.value;
        end
        r_t0 <= r_mem[k0];
        r_t1 <= r_mem[k1];
        r_r1 <= pos[FRAC_BITS-1:0];
        r_f1 <= i_frac;
        r_g1 <= i_gamma_en;
    end

    assign n_diff = $signed({1'b0, r_t1}) - $signed({1'b0, r_t0});

    always_ff @(posedge i_clk) begin
        r_prod <= n_diff * $signed({1'b0, r_r1});
        r_t0_2 <= r_t0;
        r_f2   <= r_f1;
        r_g2   <= r_g1;
    end

    // The interpolated value lies between the two entries, so it is never negative.
    assign num = $signed({2'b00, r_t0_2, FRAC_BITS'(0)}) + r_prod;
    assign gam = num[TVAL_BITS+FRAC_BITS+1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!r_g2) begin
            r_fout <= {1'b0, r_f2};
        end else if (gam > {1'b0, ONE}) begin
            r_fout <= ONE;
        end else begin
            r_fout <= gam[FRAC_BITS:0];
        end
    end

    assign o_frac = r_fout;

endmodule
`default_nettype wire

// File: hw/rtl/multichannel_color_blend.sv
// Top level of the multichannel colour blend: windowing, gamma and additive mixing.
`default_nettype none
// Each item either blends one voxel's channel samples into an RGB pixel or
// writes one entry of a channel's gamma table. The block is fully pipelined:
// it takes a new item in every cycle after reset, and a blend item's pixel
// appears on o_red, o_green and o_blue, marked by o_valid for exactly one
// cycle. Each item passes the input register, then the window division,
// which produces one quotient bit per stage over sixteen stages, then three
// stages of gamma lookup and interpolation, one of colour scaling and one of
// summing. A table write item gives no pixel; it travels down the same
// pipeline and updates the table at the point where blend items read it, so
// every item sees exactly the writes taken before it. The receiver cannot
// hold results off, and none is needed: the pipeline never stalls. busy is
// high only while reset is applied and for the cycle after it. Configuration
// registers are to be written only while no item is in flight; gamma table
// entries must be written before a blend with gamma enabled reads them.
module multichannel_color_blend
    import mcb_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output      logic                    busy,
    input  wire logic                    i_mode,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_0,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_1,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_2,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample_3,
    input  wire logic                    i_ignore_visibility,
    input  wire logic [TCH_BITS-1:0]     i_table_channel,
    input  wire logic [TIDX_BITS-1:0]    i_table_index,
    input  wire logic [TVAL_BITS-1:0]    i_table_value,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [SETUP_BITS-1:0]   i_cfg_data,
    output      logic                    o_valid,
    output      logic [COLOR_BITS-1:0]   o_red,
    output      logic [COLOR_BITS-1:0]   o_green,
    output      logic [COLOR_BITS-1:0]   o_blue
);

    // Configuration registers.
    logic [COUNT_BITS-1:0] r_count;
    t_setup                r_setup [0:CHANNELS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RST;
            for (int c = 0; c < CHANNELS; c++) begin
                r_setup[c] <= t_setup'(SETUP_RST[c]);
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COUNT:  r_count    <= i_cfg_data[COUNT_BITS-1:0];
                CFG_SETUP0: r_setup[0] <= t_setup'(i_cfg_data);
                CFG_SETUP1: r_setup[1] <= t_setup'(i_cfg_data);
                CFG_SETUP2: r_setup[2] <= t_setup'(i_cfg_data);
                CFG_SETUP3: r_setup[3] <= t_setup'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // busy covers reset and the cycle the pipeline takes to come out of it.
    logic r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy = !(r_run && i_rst_n);

    // Input register.
    logic                   r_in_valid;
    logic                   r_in_mode;
    logic [SAMPLE_BITS-1:0] r_in_sample [0:CHANNELS-1];
    logic                   r_in_ign;
    logic [TCH_BITS-1:0]    r_in_tch;
    logic [TIDX_BITS-1:0]   r_in_tidx;
    logic [TVAL_BITS-1:0]   r_in_tval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        r_in_mode      <= i_mode;
        r_in_sample[0] <= i_sample_0;
        r_in_sample[1] <= i_sample_1;
        r_in_sample[2] <= i_sample_2;
        r_in_sample[3] <= i_sample_3;
        r_in_ign       <= i_ignore_visibility;
        r_in_tch       <= i_table_channel;
        r_in_tidx      <= i_table_index;
        r_in_tval      <= i_table_value;
    end

    // A count beyond the number of channels is clamped.
    logic [COUNT_BITS:0] count_eff;
    assign count_eff = ({1'b0, r_count} > (COUNT_BITS+1)'(CHANNELS)) ?
                       (COUNT_BITS+1)'(CHANNELS) : {1'b0, r_count};

    // Item description travelling alongside the divider and gamma stages.
    t_meta n_meta;
    t_meta r_meta [0:META_DEPTH-1];

    t_kind                  kind      [0:CHANNELS-1];
    logic [SAMPLE_BITS-1:0] dividend  [0:CHANNELS-1];
    logic [SAMPLE_BITS-1:0] divisor   [0:CHANNELS-1];
    logic [FRAC_BITS-1:0]   quot      [0:CHANNELS-1];
    logic [FRAC_BITS:0]     gfrac     [0:CHANNELS-1];
    t_twr                   twr       [0:CHANNELS-1];

    t_meta m_div;
    t_meta m_col;
    assign m_div = r_meta[DIV_STAGES-1];
    assign m_col = r_meta[META_DEPTH-1];

    logic [COLOR_BITS-1:0] r_con [0:CHANNELS-1][0:COMPONENTS-1];
    logic                  r_cvalid;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
        logic [SAMPLE_BITS-1:0] s;
        logic                   active;
        logic [COLOR_BITS-1:0]  col [0:COMPONENTS-1];

        assign s = r_in_sample[c];

        // A channel takes part if it is counted, non-zero, shown and above
        // its lower window edge; an empty or inverted window then gives full colour.
        assign active = (count_eff > (COUNT_BITS+1)'(c)) && (s != '0) &&
                        (r_setup[c].visible || r_in_ign) && (s > r_setup[c].hdr_min);
        assign kind[c] = !active ? KIND_NONE :
                         (s >= r_setup[c].hdr_max) ? KIND_FULL : KIND_FRAC;
        assign dividend[c] = s - r_setup[c].hdr_min;
        assign divisor[c]  = r_setup[c].hdr_max - r_setup[c].hdr_min;

        mcb_divider u_div (
            .i_clk      (i_clk),
            .i_dividend (dividend[c]),
            .i_divisor  (divisor[c]),
            .o_quot     (quot[c])
        );

        assign twr[c].we    = m_div.valid && m_div.mode && (m_div.tch == TCH_BITS'(c));
        assign twr[c].idx   = m_div.tidx;
        assign twr[c].value = m_div.tval;

        mcb_gamma u_gamma (
            .i_clk      (i_clk),
            .i_frac     (quot[c]),
            .i_gamma_en (r_setup[c].gamma_en),
            .i_wr       (twr[c]),
            .o_frac     (gfrac[c])
        );

        assign col[0] = r_setup[c].red;
        assign col[1] = r_setup[c].green;
        assign col[2] = r_setup[c].blue;

        for (genvar j = 0; j < COMPONENTS; j++) begin : g_comp
            logic [FRAC_BITS+COLOR_BITS:0] scaled;
            assign scaled = gfrac[c] * col[j];

            always_ff @(posedge i_clk) begin
                unique case (m_col.kind[c])
                    KIND_FULL: r_con[c][j] <= col[j];
                    KIND_FRAC: r_con[c][j] <= scaled[FRAC_BITS+COLOR_BITS-1:FRAC_BITS];
                    default:   r_con[c][j] <= '0;
                endcase
            end
        end

        assign n_meta.kind[c] = kind[c];
    end

    assign n_meta.valid = r_in_valid;
    assign n_meta.mode  = r_in_mode;
    assign n_meta.tch   = r_in_tch;
    assign n_meta.tidx  = r_in_tidx;
    assign n_meta.tval  = r_in_tval;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < META_DEPTH; i++) begin
            if (!i_rst_n) begin
                r_meta[i] <= '0;
            end else if (i == 0) begin
                r_meta[i] <= n_meta;
            end else begin
                r_meta[i] <= r_meta[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= 1'b0;
        end else begin
            r_cvalid <= m_col.valid && !m_col.mode;
        end
    end

    // Additive mix with saturation at full scale.
    logic [SUM_BITS-1:0]   sum [0:COMPONENTS-1];
    logic [COLOR_BITS-1:0] sat [0:COMPONENTS-1];

    always_comb begin
        for (int j = 0; j < COMPONENTS; j++) begin
            sum[j] = '0;
            for (int c = 0; c < CHANNELS; c++) begin
                sum[j] = sum[j] + SUM_BITS'(r_con[c][j]);
            end
            sat[j] = (sum[j] > SUM_BITS'({COLOR_BITS{1'b1}})) ?
                     {COLOR_BITS{1'b1}} : sum[j][COLOR_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_cvalid;
        end
        o_red   <= sat[0];
        o_green <= sat[1];
        o_blue  <= sat[2];
    end

    // A pixel leaves only for a blend item taken earlier, never for a table write.
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && !i_mode, PIPE_LAT))
        else $error("pixel without a matching blend item");

    // A fractional channel always divides a remainder smaller than its window; the check covers channel 0.
    a_frac_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_mode && kind[0] == KIND_FRAC) |->
        (dividend[0] < divisor[0]))
        else $error("fractional channel outside its window");

    // Table write items never produce a pixel.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_col.valid && m_col.mode) |=> !r_cvalid)
        else $error("table write produced a pixel");

    // Nothing comes out of the pipeline straight after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_cvalid)
        else $error("output valid after reset");

endmodule
`default_nettype wire
